[rtl/robi_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the ray / oriented box intersection pipeline.
package robi_pkg;

    localparam int FW    = 20;  // Q11.8 / Q2.17 field width
    localparam int TW    = 32;  // Q16.16 distance width
    localparam int CW    = 60;  // packed config register width
    localparam int TOLW  = 18;  // tolerance register width
    localparam int P_W   = 21;  // center - origin
    localparam int EP_W  = 41;  // axis * p
    localparam int FP_W  = 40;  // axis * dir
    localparam int E_W   = 44;  // axis . p and slab numerators
    localparam int F_W   = 42;  // axis . dir
    localparam int AF_W  = 41;  // |axis . dir|
    localparam int EXT_W = 37;  // half size << 17
    localparam int M_W   = 43;  // numerator magnitude
    localparam int D_W   = 48;  // divisor magnitude << 6
    localparam int QB    = 31;  // quotient bits
    localparam int PR_W  = 52;  // t * dir
    localparam int NLANE = 6;   // two divisions per slab
    localparam int IDXW  = 3;

    localparam logic [IDXW-1:0] CFG_CENTER = 3'd0;
    localparam logic [IDXW-1:0] CFG_AXIS0  = 3'd1;
    localparam logic [IDXW-1:0] CFG_AXIS1  = 3'd2;
    localparam logic [IDXW-1:0] CFG_AXIS2  = 3'd3;
    localparam logic [IDXW-1:0] CFG_HALF   = 3'd4;
    localparam logic [IDXW-1:0] CFG_TOL    = 3'd5;

    localparam logic [CW-1:0]   RST_CENTER = 60'd0;
    localparam logic [CW-1:0]   RST_AXIS0  = 60'd131072;
    localparam logic [CW-1:0]   RST_AXIS1  = 60'd131072 << 20;
    localparam logic [CW-1:0]   RST_AXIS2  = 60'd131072 << 40;
    localparam logic [CW-1:0]   RST_HALF   = 60'd256 | (60'd256 << 20) | (60'd256 << 40);
    localparam logic [TOLW-1:0] RST_TOL    = 18'd1;

    localparam logic signed [TW-1:0] T_POS_SAT = 32'sh7FFF_FFFF;
    localparam logic signed [TW-1:0] T_NEG_SAT = 32'sh8000_0000;

    typedef struct packed {
        logic signed [FW-1:0] origin_x;
        logic signed [FW-1:0] origin_y;
        logic signed [FW-1:0] origin_z;
        logic signed [FW-1:0] dir_x;
        logic signed [FW-1:0] dir_y;
        logic signed [FW-1:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic                 hit;
        logic [1:0]           hit_count;
        logic signed [TW-1:0] first_t;
        logic signed [FW-1:0] first_px;
        logic signed [FW-1:0] first_py;
        logic signed [FW-1:0] first_pz;
        logic signed [TW-1:0] second_t;
        logic signed [FW-1:0] second_px;
        logic signed [FW-1:0] second_py;
        logic signed [FW-1:0] second_pz;
    } t_result;

    typedef struct packed {
        logic [CW-1:0]        center;
        logic [2:0][CW-1:0]   axis;
        logic [CW-1:0]        half;
        logic [TOLW-1:0]      tol;
    } t_cfg;

    typedef struct packed {
        logic [2:0][FW-1:0] org;
        logic [2:0][FW-1:0] dir;
    } t_geo;

    typedef struct packed {
        t_geo             geo;
        logic [NLANE-1:0] neg;
        logic [NLANE-1:0] ovf;
        logic [2:0]       par;
        logic [2:0]       outside;
    } t_side;

endpackage

[rtl/robi_front.sv]
`timescale 1ns / 1ps
// Front end: dot products, slab numerators, parallel test and divider setup.
module robi_front (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  robi_pkg::t_ray                              i_ray,
    input  robi_pkg::t_cfg                              i_cfg,
    output logic                                        o_valid,
    output logic [robi_pkg::NLANE-1:0][robi_pkg::M_W-1:0] o_n,
    output logic [robi_pkg::NLANE-1:0][robi_pkg::D_W-1:0] o_d,
    output robi_pkg::t_side                             o_side
);
    import robi_pkg::*;

    // stage 1
    logic             r_v1;
    t_geo             r_geo1;
    logic [2:0][P_W-1:0] r_p1;
    // stage 2
    logic             r_v2;
    t_geo             r_geo2;
    logic [2:0][2:0][EP_W-1:0] r_ep2;
    logic [2:0][2:0][FP_W-1:0] r_fp2;
    // stage 3
    logic             r_v3;
    t_geo             r_geo3;
    logic [2:0][E_W-1:0] r_e3;
    logic [2:0][F_W-1:0] r_f3;
    // stage 4
    logic             r_v4;
    t_geo             r_geo4;
    logic [NLANE-1:0][E_W-1:0] r_num4;
    logic [2:0][AF_W-1:0] r_af4;
    logic [2:0]       r_sf4;
    logic [2:0]       r_out4;
    // stage 5
    logic             r_v5;
    t_geo             r_geo5;
    logic [NLANE-1:0][M_W-1:0] r_n5;
    logic [NLANE-1:0] r_neg5;
    logic [2:0][D_W-1:0] r_d5;
    logic [2:0]       r_par5;
    logic [2:0]       r_out5;
    // stage 6
    logic             r_v6;
    logic [NLANE-1:0][M_W-1:0] r_n6;
    logic [NLANE-1:0][D_W-1:0] r_d6;
    t_side            r_side6;

    t_geo                      n_geo1;
    logic [2:0][P_W-1:0]       n_p1;
    logic [2:0][2:0][EP_W-1:0] n_ep2;
    logic [2:0][2:0][FP_W-1:0] n_fp2;
    logic [2:0][E_W-1:0]       n_e3;
    logic [2:0][F_W-1:0]       n_f3;
    logic [NLANE-1:0][E_W-1:0] n_num4;
    logic [2:0][AF_W-1:0]      n_af4;
    logic [2:0]                n_sf4;
    logic [2:0]                n_out4;
    logic [NLANE-1:0][M_W-1:0] n_n5;
    logic [NLANE-1:0]          n_neg5;
    logic [2:0][D_W-1:0]       n_d5;
    logic [2:0]                n_par5;
    logic [NLANE-1:0]          n_ovf6;

    // stage 1: p = center - origin
    always_comb begin : p_s1
        logic signed [FW-1:0] v_c;
        n_geo1.org = {i_ray.origin_z, i_ray.origin_y, i_ray.origin_x};
        n_geo1.dir = {i_ray.dir_z, i_ray.dir_y, i_ray.dir_x};
        for (int k = 0; k < 3; k++) begin
            v_c     = $signed(i_cfg.center[FW*k +: FW]);
            n_p1[k] = P_W'(v_c) - P_W'($signed(n_geo1.org[k]));
        end
    end

    // stage 2: the eighteen products
    always_comb begin : p_s2
        logic signed [FW-1:0]   v_a;
        logic signed [P_W-1:0]  v_p;
        logic signed [FW-1:0]   v_dir;
        logic signed [EP_W-1:0] v_ep;
        logic signed [FP_W-1:0] v_fp;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                v_a         = $signed(i_cfg.axis[i][FW*k +: FW]);
                v_p         = $signed(r_p1[k]);
                v_dir       = $signed(r_geo1.dir[k]);
                v_ep        = v_a * v_p;
                v_fp        = v_a * v_dir;
                n_ep2[i][k] = v_ep;
                n_fp2[i][k] = v_fp;
            end
        end
    end

    // stage 3: dot products
    always_comb begin : p_s3
        for (int i = 0; i < 3; i++) begin
            n_e3[i] = E_W'($signed(r_ep2[i][0])) + E_W'($signed(r_ep2[i][1]))
                    + E_W'($signed(r_ep2[i][2]));
            n_f3[i] = F_W'($signed(r_fp2[i][0])) + F_W'($signed(r_fp2[i][1]))
                    + F_W'($signed(r_fp2[i][2]));
        end
    end

    // stage 4: numerators e +/- ext, |f|, origin outside the slab
    always_comb begin : p_s4
        logic signed [E_W-1:0] v_ext;
        logic signed [E_W-1:0] v_e;
        logic signed [F_W-1:0] v_f;
        logic signed [F_W-1:0] v_fa;
        for (int i = 0; i < 3; i++) begin
            v_ext         = $signed({{(E_W-EXT_W){1'b0}}, i_cfg.half[FW*i +: FW], 17'd0});
            v_e           = $signed(r_e3[i]);
            v_f           = $signed(r_f3[i]);
            n_num4[2*i]   = v_e + v_ext;
            n_num4[2*i+1] = v_e - v_ext;
            v_fa          = v_f[F_W-1] ? -v_f : v_f;
            n_af4[i]      = v_fa[AF_W-1:0];
            n_sf4[i]      = v_f[F_W-1];
            n_out4[i]     = (v_e < -v_ext) || (v_e > v_ext);
        end
    end

    // stage 5: magnitudes, quotient sign, parallel test, scaled divisor
    always_comb begin : p_s5
        logic signed [E_W-1:0] v_num;
        logic signed [E_W-1:0] v_mag;
        for (int l = 0; l < NLANE; l++) begin
            v_num     = $signed(r_num4[l]);
            v_mag     = v_num[E_W-1] ? -v_num : v_num;
            n_n5[l]   = v_mag[M_W-1:0];
            n_neg5[l] = v_num[E_W-1] ^ r_sf4[l/2];
        end
        for (int i = 0; i < 3; i++) begin
            n_par5[i] = {1'b0, r_af4[i]} <= {{(AF_W+1-TOLW-17){1'b0}}, i_cfg.tol, 17'd0};
            n_d5[i]   = {1'b0, r_af4[i], 6'd0};
        end
    end

    // stage 6: quotient overflow (|num| / |f| >= 64)
    always_comb begin : p_s6
        for (int l = 0; l < NLANE; l++) begin
            n_ovf6[l] = {{(D_W-M_W){1'b0}}, r_n5[l]} >= r_d5[l/2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geo1 <= n_geo1;
            r_p1   <= n_p1;
            r_geo2 <= r_geo1;
            r_ep2  <= n_ep2;
            r_fp2  <= n_fp2;
            r_geo3 <= r_geo2;
            r_e3   <= n_e3;
            r_f3   <= n_f3;
            r_geo4 <= r_geo3;
            r_num4 <= n_num4;
            r_af4  <= n_af4;
            r_sf4  <= n_sf4;
            r_out4 <= n_out4;
            r_geo5 <= r_geo4;
            r_n5   <= n_n5;
            r_neg5 <= n_neg5;
            r_d5   <= n_d5;
            r_par5 <= n_par5;
            r_out5 <= r_out4;
            r_n6   <= r_n5;
            for (int l = 0; l < NLANE; l++) begin
                r_d6[l] <= r_d5[l/2];
            end
            r_side6.geo     <= r_geo5;
            r_side6.neg     <= r_neg5;
            r_side6.ovf     <= n_ovf6;
            r_side6.par     <= r_par5;
            r_side6.outside <= r_out5;
        end
    end

    assign o_valid = r_v6;
    assign o_n     = r_n6;
    assign o_d     = r_d6;
    assign o_side  = r_side6;

endmodule

[rtl/robi_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, six lanes.
module robi_div (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  logic [robi_pkg::NLANE-1:0][robi_pkg::M_W-1:0] i_n,
    input  logic [robi_pkg::NLANE-1:0][robi_pkg::D_W-1:0] i_d,
    input  robi_pkg::t_side                              i_side,
    output logic                                         o_valid,
    output logic [robi_pkg::NLANE-1:0][robi_pkg::QB-1:0]  o_q,
    output robi_pkg::t_side                              o_side
);
    import robi_pkg::*;

    logic [QB-1:0]                 r_v;
    logic [NLANE-1:0][D_W-1:0]     r_rem [QB];
    logic [NLANE-1:0][D_W-1:0]     r_dv  [QB];
    logic [NLANE-1:0][QB-1:0]      r_q   [QB];
    t_side                         r_sd  [QB];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic                      w_v;
        logic [NLANE-1:0][D_W-1:0] w_rem;
        logic [NLANE-1:0][D_W-1:0] w_dv;
        logic [NLANE-1:0][QB-1:0]  w_q;
        t_side                     w_sd;
        logic [NLANE-1:0][D_W-1:0] n_rem;
        logic [NLANE-1:0][QB-1:0]  n_q;

        if (s == 0) begin : g_head
            assign w_v  = i_valid;
            assign w_dv = i_d;
            assign w_q  = '0;
            assign w_sd = i_side;
            for (genvar l = 0; l < NLANE; l++) begin : g_lane
                assign w_rem[l] = {{(D_W-M_W){1'b0}}, i_n[l]};
            end
        end else begin : g_body
            assign w_v   = r_v[s-1];
            assign w_rem = r_rem[s-1];
            assign w_dv  = r_dv[s-1];
            assign w_q   = r_q[s-1];
            assign w_sd  = r_sd[s-1];
        end

        // shift the partial remainder, subtract the divisor where it fits
        always_comb begin : p_step
            logic [D_W:0] v_rem2;
            logic [D_W:0] v_diff;
            logic         v_ge;
            for (int l = 0; l < NLANE; l++) begin
                v_rem2   = {w_rem[l], 1'b0};
                v_diff   = v_rem2 - {1'b0, w_dv[l]};
                v_ge     = v_rem2 >= {1'b0, w_dv[l]};
                n_rem[l] = v_ge ? v_diff[D_W-1:0] : v_rem2[D_W-1:0];
                n_q[l]   = {w_q[l][QB-2:0], v_ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_dv[s]  <= w_dv;
                r_q[s]   <= n_q;
                r_sd[s]  <= w_sd;
            end
        end
    end

    assign o_valid = r_v[QB-1];
    assign o_q     = r_q[QB-1];
    assign o_side  = r_sd[QB-1];

endmodule

[rtl/robi_back.sv]
`timescale 1ns / 1ps
// Back end: signed distances, slab interval, hit selection and hit points.
module robi_back (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic [robi_pkg::NLANE-1:0][robi_pkg::QB-1:0] i_q,
    input  robi_pkg::t_side                             i_side,
    output logic                                        o_valid,
    output robi_pkg::t_result                           o_res
);
    import robi_pkg::*;

    function automatic logic [FW-1:0] sat_pt(input logic signed [FW+7:0] v);
        logic [FW-1:0] res;
        if (v > (FW+8)'(signed'(20'sh7FFFF))) begin
            res = 20'h7FFFF;
        end else if (v < (FW+8)'(signed'(20'sh80000))) begin
            res = 20'h80000;
        end else begin
            res = v[FW-1:0];
        end
        return res;
    endfunction

    // B1
    logic r_v1;
    logic [NLANE-1:0][TW-1:0] r_t1;
    t_geo r_geo1;
    logic [2:0] r_par1, r_out1;
    // B2
    logic r_v2;
    logic [2:0][TW-1:0] r_lo2, r_hi2;
    t_geo r_geo2;
    logic [2:0] r_par2, r_out2;
    // B3
    logic r_v3;
    logic [TW-1:0] r_tmin3, r_tmax3;
    logic r_any3;
    t_geo r_geo3;
    // B4
    logic r_v4;
    logic [TW-1:0] r_ft4, r_st4;
    logic r_has1_4, r_has2_4;
    logic [1:0] r_cnt4;
    t_geo r_geo4;
    // B5
    logic r_v5;
    logic [TW-1:0] r_ft5, r_st5;
    logic r_has1_5, r_has2_5;
    logic [1:0] r_cnt5;
    logic [2:0][FW-1:0] r_org5;
    logic [2:0][PR_W-1:0] r_pr1_5, r_pr2_5;
    // B6
    logic r_v6;
    t_result r_res6;

    logic [NLANE-1:0][TW-1:0] n_t1;
    logic [2:0][TW-1:0] n_lo2, n_hi2;
    logic [TW-1:0] n_tmin3, n_tmax3;
    logic [TW-1:0] n_ft4, n_st4;
    logic n_has1_4, n_has2_4;
    logic [1:0] n_cnt4;
    logic [2:0][PR_W-1:0] n_pr1_5, n_pr2_5;
    t_result n_res6;

    // B1: apply sign, saturate on quotient overflow
    always_comb begin : p_b1
        logic signed [TW-1:0] v_q;
        for (int l = 0; l < NLANE; l++) begin
            v_q = $signed({1'b0, i_q[l]});
            if (i_side.ovf[l]) begin
                n_t1[l] = i_side.neg[l] ? T_NEG_SAT : T_POS_SAT;
            end else begin
                n_t1[l] = i_side.neg[l] ? -v_q : v_q;
            end
        end
    end

    // B2: order the two plane distances
    always_comb begin : p_b2
        logic signed [TW-1:0] v_a, v_b;
        for (int i = 0; i < 3; i++) begin
            v_a      = $signed(r_t1[2*i]);
            v_b      = $signed(r_t1[2*i+1]);
            n_lo2[i] = (v_a > v_b) ? v_b : v_a;
            n_hi2[i] = (v_a > v_b) ? v_a : v_b;
        end
    end

    // B3: interval over non-parallel slabs
    always_comb begin : p_b3
        logic signed [TW-1:0] v_lo [3];
        logic signed [TW-1:0] v_hi [3];
        logic signed [TW-1:0] v_mx, v_mn;
        for (int i = 0; i < 3; i++) begin
            v_lo[i] = r_par2[i] ? T_NEG_SAT : $signed(r_lo2[i]);
            v_hi[i] = r_par2[i] ? T_POS_SAT : $signed(r_hi2[i]);
        end
        v_mx    = (v_lo[0] > v_lo[1]) ? v_lo[0] : v_lo[1];
        v_mn    = (v_hi[0] < v_hi[1]) ? v_hi[0] : v_hi[1];
        n_tmin3 = (v_lo[2] > v_mx) ? v_lo[2] : v_mx;
        n_tmax3 = (v_hi[2] < v_mn) ? v_hi[2] : v_mn;
    end

    // B4: miss test and choice of reported distances
    always_comb begin : p_b4
        logic signed [TW-1:0] v_tmin, v_tmax;
        logic v_miss, v_pmin, v_pmax;
        v_tmin   = $signed(r_tmin3);
        v_tmax   = $signed(r_tmax3);
        v_miss   = r_any3 || (v_tmin > v_tmax) || (v_tmax < 0);
        v_pmin   = !v_miss && (v_tmin > 0);
        v_pmax   = !v_miss && (v_tmax > 0);
        n_has1_4 = v_pmin || v_pmax;
        n_has2_4 = v_pmin && v_pmax;
        n_cnt4   = {1'b0, v_pmin} + {1'b0, v_pmax};
        n_ft4    = v_pmin ? r_tmin3 : (v_pmax ? r_tmax3 : '0);
        n_st4    = n_has2_4 ? r_tmax3 : '0;
    end

    // B5: t * dir
    always_comb begin : p_b5
        logic signed [PR_W-1:0] v_p1, v_p2;
        logic signed [FW-1:0]   v_d;
        for (int k = 0; k < 3; k++) begin
            v_d        = $signed(r_geo4.dir[k]);
            v_p1       = $signed(r_ft4) * v_d;
            v_p2       = $signed(r_st4) * v_d;
            n_pr1_5[k] = v_p1;
            n_pr2_5[k] = v_p2;
        end
    end

    // B6: round to Q.8, add origin, saturate
    always_comb begin : p_b6
        logic signed [PR_W-1:0] v_w;
        logic signed [FW+7:0]   v_s;
        logic [2:0][FW-1:0]     v_pt1, v_pt2;
        for (int k = 0; k < 3; k++) begin
            v_w      = $signed(r_pr1_5[k]) + PR_W'(signed'(26'sd16777216));
            v_s      = (FW+8)'(v_w >>> 25) + (FW+8)'($signed(r_org5[k]));
            v_pt1[k] = r_has1_5 ? sat_pt(v_s) : '0;
            v_w      = $signed(r_pr2_5[k]) + PR_W'(signed'(26'sd16777216));
            v_s      = (FW+8)'(v_w >>> 25) + (FW+8)'($signed(r_org5[k]));
            v_pt2[k] = r_has2_5 ? sat_pt(v_s) : '0;
        end
        n_res6.hit       = r_has1_5;
        n_res6.hit_count = r_cnt5;
        n_res6.first_t   = r_ft5;
        n_res6.first_px  = v_pt1[0];
        n_res6.first_py  = v_pt1[1];
        n_res6.first_pz  = v_pt1[2];
        n_res6.second_t  = r_st5;
        n_res6.second_px = v_pt2[0];
        n_res6.second_py = v_pt2[1];
        n_res6.second_pz = v_pt2[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1     <= n_t1;
            r_geo1   <= i_side.geo;
            r_par1   <= i_side.par;
            r_out1   <= i_side.outside;
            r_lo2    <= n_lo2;
            r_hi2    <= n_hi2;
            r_geo2   <= r_geo1;
            r_par2   <= r_par1;
            r_out2   <= r_out1;
            r_tmin3  <= n_tmin3;
            r_tmax3  <= n_tmax3;
            r_any3   <= |(r_par2 & r_out2);
            r_geo3   <= r_geo2;
            r_ft4    <= n_ft4;
            r_st4    <= n_st4;
            r_has1_4 <= n_has1_4;
            r_has2_4 <= n_has2_4;
            r_cnt4   <= n_cnt4;
            r_geo4   <= r_geo3;
            r_ft5    <= r_ft4;
            r_st5    <= r_st4;
            r_has1_5 <= r_has1_4;
            r_has2_5 <= r_has2_4;
            r_cnt5   <= r_cnt4;
            r_org5   <= r_geo4.org;
            r_pr1_5  <= n_pr1_5;
            r_pr2_5  <= n_pr2_5;
            r_res6   <= n_res6;
        end
    end

    assign o_valid = r_v6;
    assign o_res   = r_res6;

endmodule

[rtl/ray_oriented_box_intersect_top.sv]
`timescale 1ns / 1ps
// Top level: config registers, pipeline and output skid buffer.
//
// Ray / oriented box slab test, one ray per item.
// Input channel: i_valid / o_ready carry one ray (origin Q11.8, direction
// Q2.17). Output channel: o_valid / i_ready carry one result item per ray
// (hit flag, count, up to two Q16.16 distances and their Q11.8 points).
// Config: i_cfg_we writes i_cfg_data into the register chosen by i_cfg_idx
// (center, three axes, half sizes, parallel tolerance); unused indexes are
// dropped. Write only while no ray is in flight.
// Throughput: one item per cycle while the skid register is empty. The path
// from the accepting edge to o_valid runs through 6 front stages, the 31-stage
// divider (one quotient bit per stage, six lanes in parallel), 6 back stages
// and the output register; the first front stage loads at the accepting edge.
// Reset (synchronous, active low) clears every valid bit and loads the unit
// box at the origin with tolerance 1 LSB.
// Stall: the whole pipeline holds while the skid register is full. The
// output register and the skid register let one finished item wait while
// the pipeline still advances once, so o_ready is a registered signal.
module ray_oriented_box_intersect_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  robi_pkg::t_ray                i_ray,
    output logic                          o_valid,
    input  logic                          i_ready,
    output robi_pkg::t_result             o_result,
    input  logic                          i_cfg_we,
    input  logic [robi_pkg::IDXW-1:0]     i_cfg_idx,
    input  logic [robi_pkg::CW-1:0]       i_cfg_data
);
    import robi_pkg::*;

    t_cfg  r_cfg;
    logic  w_en;

    logic                      w_f_v;
    logic [NLANE-1:0][M_W-1:0] w_f_n;
    logic [NLANE-1:0][D_W-1:0] w_f_d;
    t_side                     w_f_side;
    logic                      w_d_v;
    logic [NLANE-1:0][QB-1:0]  w_d_q;
    t_side                     w_d_side;
    logic                      w_b_v;
    t_result                   w_b_res;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    w_push, w_take;

    // config register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center  <= RST_CENTER;
            r_cfg.axis[0] <= RST_AXIS0;
            r_cfg.axis[1] <= RST_AXIS1;
            r_cfg.axis[2] <= RST_AXIS2;
            r_cfg.half    <= RST_HALF;
            r_cfg.tol     <= RST_TOL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER: r_cfg.center  <= i_cfg_data;
                CFG_AXIS0:  r_cfg.axis[0] <= i_cfg_data;
                CFG_AXIS1:  r_cfg.axis[1] <= i_cfg_data;
                CFG_AXIS2:  r_cfg.axis[2] <= i_cfg_data;
                CFG_HALF:   r_cfg.half    <= i_cfg_data;
                CFG_TOL:    r_cfg.tol     <= i_cfg_data[TOLW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the skid slot is free
    assign w_en    = !r_skid_v;
    assign o_ready = w_en;

    robi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_ray   (i_ray),
        .i_cfg   (r_cfg),
        .o_valid (w_f_v),
        .o_n     (w_f_n),
        .o_d     (w_f_d),
        .o_side  (w_f_side)
    );

    robi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_v),
        .i_n     (w_f_n),
        .i_d     (w_f_d),
        .i_side  (w_f_side),
        .o_valid (w_d_v),
        .o_q     (w_d_q),
        .o_side  (w_d_side)
    );

    robi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d_v),
        .i_q     (w_d_q),
        .i_side  (w_d_side),
        .o_valid (w_b_v),
        .o_res   (w_b_res)
    );

    // last stage item leaves the pipeline on an advancing edge
    assign w_push = w_b_v && w_en;
    assign w_take = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || w_take) begin
            r_out_v  <= r_skid_v || w_push;
            r_skid_v <= 1'b0;
        end else if (w_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || w_take) begin
            r_out <= r_skid_v ? r_skid : w_b_res;
        end else if (w_push) begin
            r_skid <= w_b_res;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

    // skid slot only fills behind a held output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid item without output item");

    // a full skid slot clears once the output moves
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_ready) |=> !r_skid_v)
        else $error("skid slot did not drain");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.hit == (o_result.hit_count != 2'd0))
                    && (o_result.hit_count != 2'd3))
        else $error("hit flag and count disagree");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.hit_count != 2'd2)) |-> (o_result.second_t == '0))
        else $error("second distance set without second hit");

    a_hit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.hit) |-> (o_result.first_t > 0))
        else $error("hit with non-positive distance");

endmodule

[bench/ray_oriented_box_intersect_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the ray / oriented box slab test pipeline.
module ray_oriented_box_intersect_top_tb;
    import robi_pkg::*;

    localparam int PIPE_LAT  = 44;
    localparam longint LIMIT = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    t_ray              i_ray = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_result           o_result;
    logic              i_cfg_we = 1'b0;
    logic [IDXW-1:0]   i_cfg_idx = '0;
    logic [CW-1:0]     i_cfg_data = '0;

    ray_oriented_box_intersect_top dut (.*);

    always #2 i_clk = ~i_clk;

    // Local copy of the box setup, updated alongside every register write.
    logic [CW-1:0]   box_ctr, box_half;
    logic [CW-1:0]   box_ax [3];
    logic [TOLW-1:0] box_tol;

    t_ray    ray_q [$];
    t_result hit_q [$];
    int      n_err = 0;
    longint  cyc = 0;
    bit      stim_done = 0;
    bit      send_hold = 0;   // sender pause requested by the stimulus
    int      hold_rx = 0;     // long receiver hold-off, counted down below
    int      tx_gap = 0, rx_gap = 0;

    function automatic longint sx20(logic [FW-1:0] v);
        return longint'($signed(v));
    endfunction

    // num * 2^25 / den, toward zero, saturating to 32 bits.
    // Long division keeps every step inside 64 bits.
    function automatic longint slab_dist(longint num, longint den);
        bit     neg;
        longint n, d, q, r;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        r = n % d;
        if (q >= 64) return neg ? -64'sd2147483648 : 64'sd2147483647;
        for (int i = 0; i < 25; i++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= d) begin
                r = r - d;
                q = q + 1;
            end
        end
        if (neg) return -q;
        return q > 2147483647 ? 2147483647 : q;
    endfunction

    function automatic logic [FW-1:0] hit_coord(longint t, longint o, longint d);
        longint w, r, v;
        w = t * d + (64'sd1 <<< 24);
        r = w >>> 25;   // arithmetic shift is floor
        v = o + r;
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[FW-1:0];
    endfunction

    function automatic t_result trace_ray(t_ray r);
        t_result res;
        longint org[3], dir[3], p[3];
        longint tmin, tmax, tol, e, f, af, ext, a, t1, t2, s;
        bit miss;
        int cnt;
        res = '0;
        tmin = -64'sd2147483648;
        tmax = 64'sd2147483647;
        tol = longint'(box_tol) << 17;
        miss = 0;
        cnt = 0;
        org[0] = sx20(r.origin_x); org[1] = sx20(r.origin_y); org[2] = sx20(r.origin_z);
        dir[0] = sx20(r.dir_x); dir[1] = sx20(r.dir_y); dir[2] = sx20(r.dir_z);
        for (int k = 0; k < 3; k++) p[k] = sx20(box_ctr[20*k +: 20]) - org[k];
        for (int i = 0; i < 3 && !miss; i++) begin
            e = 0;
            f = 0;
            ext = longint'(box_half[20*i +: 20]) << 17;
            for (int k = 0; k < 3; k++) begin
                a = sx20(box_ax[i][20*k +: 20]);
                e += a * p[k];
                f += a * dir[k];
            end
            af = f < 0 ? -f : f;
            if (af > tol) begin
                t1 = slab_dist(e + ext, f);
                t2 = slab_dist(e - ext, f);
                if (t1 > t2) begin
                    s = t1; t1 = t2; t2 = s;
                end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax || tmax < 0) miss = 1;
            end else if (e < -ext || e > ext) begin
                miss = 1;
            end
        end
        if (miss) return res;
        if (tmin > 0) begin
            res.first_t  = tmin[31:0];
            res.first_px = hit_coord(tmin, org[0], dir[0]);
            res.first_py = hit_coord(tmin, org[1], dir[1]);
            res.first_pz = hit_coord(tmin, org[2], dir[2]);
            cnt++;
        end
        if (tmax > 0) begin
            if (cnt != 0) begin
                res.second_t  = tmax[31:0];
                res.second_px = hit_coord(tmax, org[0], dir[0]);
                res.second_py = hit_coord(tmax, org[1], dir[1]);
                res.second_pz = hit_coord(tmax, org[2], dir[2]);
            end else begin
                res.first_t  = tmax[31:0];
                res.first_px = hit_coord(tmax, org[0], dir[0]);
                res.first_py = hit_coord(tmax, org[1], dir[1]);
                res.first_pz = hit_coord(tmax, org[2], dir[2]);
            end
            cnt++;
        end
        res.hit = cnt != 0;
        res.hit_count = cnt[1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 50) return 0;
        if (g < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: offers queued rays; expectation is made at the accepting edge.
    // A zero gap keeps valid high and presents the next ray right away.
    always @(posedge i_clk) begin
        int g;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                hit_q.push_back(trace_ray(i_ray));
                void'(ray_q.pop_front());
                g = pick_gap();
                if (g == 0 && ray_q.size() > 0 && !send_hold) begin
                    i_ray <= ray_q[0];
                    tx_gap <= 0;
                end else begin
                    tx_gap <= g;
                    i_valid <= 1'b0;
                end
            end else if (!i_valid) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                end else if (ray_q.size() > 0 && !send_hold) begin
                    i_ray <= ray_q[0];
                    i_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (hit_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %p", $time, o_result);
                    n_err++;
                end else begin
                    want = hit_q.pop_front();
                    if (o_result !== want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, o_result);
                        n_err++;
                    end
                end
            end
            if (hold_rx > 0) begin
                hold_rx <= hold_rx - 1;
                i_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_gap <= pick_gap();
            end
        end
    end

    // Run limit and end of test.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("ray_oriented_box_intersect_top test failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [IDXW-1:0] idx, logic [CW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER: box_ctr = val;
            CFG_AXIS0:  box_ax[0] = val;
            CFG_AXIS1:  box_ax[1] = val;
            CFG_AXIS2:  box_ax[2] = val;
            CFG_HALF:   box_half = val;
            CFG_TOL:    box_tol = val[TOLW-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (ray_q.size() > 0 || i_valid || hit_q.size() > 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] pack3(int x, int y, int z);
        logic [FW-1:0] a, b, c;
        a = FW'(x); b = FW'(y); c = FW'(z);
        return {c, b, a};
    endfunction

    function automatic t_ray mk_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        t_ray r;
        r.origin_x = FW'(ox); r.origin_y = FW'(oy); r.origin_z = FW'(oz);
        r.dir_x = FW'(dx); r.dir_y = FW'(dy); r.dir_z = FW'(dz);
        return r;
    endfunction

    // Mostly rays aimed near the box center so that hits are common.
    function automatic t_ray rand_ray(int span);
        t_ray         r;
        int           ox, oy, oz;
        logic [127:0] v_bits;
        r = '0;
        if ($urandom_range(0, 9) < 2) begin
            v_bits = {$urandom, $urandom, $urandom, $urandom};
            r = v_bits[$bits(t_ray)-1:0];
        end else begin
            ox = int'(sx20(box_ctr[19:0])) + $signed($urandom_range(0, 2*span)) - span;
            oy = int'(sx20(box_ctr[39:20])) + $signed($urandom_range(0, 2*span)) - span;
            oz = int'(sx20(box_ctr[59:40])) + $signed($urandom_range(0, 2*span)) - span;
            r.origin_x = FW'(ox); r.origin_y = FW'(oy); r.origin_z = FW'(oz);
            r.dir_x = FW'((ox < sx20(box_ctr[19:0]) ? 1 : -1) * $urandom_range(0, 150000));
            r.dir_y = FW'((oy < sx20(box_ctr[39:20]) ? 1 : -1) * $urandom_range(0, 150000));
            r.dir_z = FW'((oz < sx20(box_ctr[59:40]) ? 1 : -1) * $urandom_range(0, 150000));
            if ($urandom_range(0, 7) == 0) r.dir_y = FW'($urandom_range(0, 2));
        end
        return r;
    endfunction

    initial begin
        box_ctr = RST_CENTER;
        box_ax[0] = RST_AXIS0; box_ax[1] = RST_AXIS1; box_ax[2] = RST_AXIS2;
        box_half = RST_HALF;
        box_tol = RST_TOL;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset box, axis-aligned and parallel cases, field extremes.
        ray_q.push_back(mk_ray(-1024, 0, 0, 131072, 0, 0));        // two hits
        ray_q.push_back(mk_ray(0, 0, 0, 131072, 0, 0));            // inside, one hit
        ray_q.push_back(mk_ray(1024, 0, 0, 131072, 0, 0));         // behind, miss
        ray_q.push_back(mk_ray(0, 0, 0, 0, 0, 0));                 // all parallel inside
        ray_q.push_back(mk_ray(0, 1024, 0, 131072, 0, 0));         // parallel outside
        ray_q.push_back(mk_ray(-524288, -524288, -524288, 524287, 524287, 524287));
        ray_q.push_back(mk_ray(524287, 524287, 524287, -524288, -524288, -524288));
        ray_q.push_back(mk_ray(-524288, 0, 0, 1, 0, 0));
        ray_q.push_back(mk_ray(-300, -300, 0, 131072, 131072, 0));
        ray_q.push_back(mk_ray(0, 0, -2000, 0, 0, 2));             // large distance
        ray_q.push_back(mk_ray(0, -256, 0, 0, 131072, 0));         // grazing entry at 0
        ray_q.push_back('1);
        ray_q.push_back('0);
        drain();

        // Rotated box, wide tolerance, offset center.
        cfg_write(CFG_CENTER, pack3(500, -300, 200));
        cfg_write(CFG_AXIS0, pack3(92682, 92682, 0));
        cfg_write(CFG_AXIS1, pack3(-92682, 92682, 0));
        cfg_write(CFG_AXIS2, pack3(0, 0, 131072));
        cfg_write(CFG_HALF, pack3(700, 300, 1200));
        cfg_write(CFG_TOL, 60'd131072);
        cfg_write(3'd7, '1);                                        // unused index
        ray_q.push_back(mk_ray(500, -300, 200, 100, 100, 100));     // parallel under tol
        for (int n = 0; n < 150; n++) ray_q.push_back(rand_ray(3000));
        // Long receiver stall while the sender keeps offering.
        hold_rx = 300;
        drain();

        // Sender pause until everything has come back, then tiny tolerance.
        send_hold = 1;
        drain();
        send_hold = 0;
        cfg_write(CFG_TOL, 60'd0);
        cfg_write(CFG_HALF, pack3(1, 524287, 30000));
        cfg_write(CFG_CENTER, pack3(-524288, 524287, 0));
        for (int n = 0; n < 150; n++) ray_q.push_back(rand_ray(60000));
        drain();

        // Random register contents, including extreme values.
        cfg_write(CFG_CENTER, CW'({$urandom, $urandom}));
        cfg_write(CFG_AXIS0, '1);
        cfg_write(CFG_AXIS1, CW'({$urandom, $urandom}));
        cfg_write(CFG_AXIS2, pack3(-524288, 524287, 1));
        cfg_write(CFG_HALF, '1);
        cfg_write(CFG_TOL, CW'({$urandom, $urandom}));
        for (int n = 0; n < 150; n++) ray_q.push_back(rand_ray(20000));
        drain();

        if (n_err == 0)
            $display("ray_oriented_box_intersect_top test passed");
        else
            $display("ray_oriented_box_intersect_top test failed");
        $finish;
    end
endmodule
